// File: design/pid_position_motor_drive_core_defines.svh
// Assertion macros for the PID position motor drive core.
// Used by files that check their own logic; depends on nothing else.
`ifndef PID_POSITION_MOTOR_DRIVE_CORE_DEFINES_SVH
`define PID_POSITION_MOTOR_DRIVE_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// Check a property on every rising edge of clk_i outside reset.
`define PPMD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ppmd assertion failed");
// Check that the antecedent implies the consequent in the same cycle.
`define PPMD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ppmd implication failed");
`else
`define PPMD_ASSERT(lbl, prop)
`define PPMD_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// File: design/ppmd_pkg.sv
// Package for the PID position motor drive core: beat types, codes, constants.
// Used by ppmd_div, pid_position_motor_drive_core and the testbench; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package ppmd_pkg;

  localparam int unsigned PWM_TOP_DEF = 12500;
  localparam int unsigned DIV_NUM_W   = 49;
  localparam int unsigned DIV_DEN_W   = 23;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_NUM_W);
  localparam logic [DIV_DEN_W-1:0] FULL_POWER_Q16 = 23'd6553600;

  // Reciprocal of 100 in Q.30, exact floor(x / 100) for any x below 2^23
  localparam logic [23:0] DUTY_RECIP = 24'hA3D70B;
  localparam int unsigned DUTY_SHIFT = 30;

  typedef struct packed {
    logic signed [31:0] encoder_position;
    logic signed [31:0] target_position;
  } in_item_t;

  typedef struct packed {
    logic [13:0] duty_level;
    logic        drive_forward;
    logic        drive_reverse;
    logic        direction_changed;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [7:0] {
    REG_GAIN_P   = 8'd0,
    REG_GAIN_I   = 8'd1,
    REG_GAIN_D   = 8'd2,
    REG_PERIOD   = 8'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_BRAKE   = 2'd0,
    MODE_FORWARD = 2'd1,
    MODE_REVERSE = 2'd2
  } bridge_mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_D,
    ST_MUL,
    ST_FIN,
    ST_SCALE,
    ST_RCP_LO,
    ST_RCP_HI,
    ST_RCP_SUM,
    ST_HOLD
  } ppmd_state_e;

  typedef enum logic [3:0] {
    STEP_SUM   = 4'd0,
    STEP_P_LO  = 4'd1,
    STEP_P_HI  = 4'd2,
    STEP_D_LO  = 4'd3,
    STEP_D_HI  = 4'd4,
    STEP_I_0   = 4'd5,
    STEP_I_1   = 4'd6,
    STEP_I_2   = 4'd7,
    STEP_DRAIN = 4'd8
  } mul_step_e;

endpackage
`default_nettype wire

// File: design/pid_position_motor_drive_core.sv
// PID position motor drive core: top level with sequencer and shared multiplier.
// Depends on ppmd_pkg, ppmd_div and the assertion macro header.
//
// Usage:
//   Input channel in_valid_i / in_stall_o / in_data_i carries one beat with
//   the encoder and target positions. Output channel out_valid_o /
//   out_stall_i / out_data_o carries one beat per input: duty level, bridge
//   direction and a direction change flag. The configuration channel
//   cfg_valid_i / cfg_ready_o writes gains and the sample period by index;
//   it is always ready. The user must see that it is written only while the
//   core is idle; the core itself does not enforce this. An item passes from
//   acceptance to the output register through the one-bit-per-cycle divider
//   that forms the derivative, nine steps of the shared 33x17 multiplier, a
//   state that combines the terms, the states that scale the magnitude to the
//   duty level (PWM_TOP product, then a reciprocal multiply by 1/100 in two
//   halves on the same multiplier) and a hold state that loads the output.
//   in_stall_o stays high until then, so a new beat waits for that load.
//   The output register holds a finished beat while the receiver stalls; a
//   second result waits inside the core until the register frees up.
//   Reset clears gains to zero, the period to 65535, the last error and the
//   error sum to zero and the bridge to brake.
`timescale 1ns / 1ps
`default_nettype none
`include "pid_position_motor_drive_core_defines.svh"
module pid_position_motor_drive_core import ppmd_pkg::*; #(
  parameter int unsigned PwmTop = PWM_TOP_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_item_t        out_data_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  localparam logic [15:0] PwmTopW = 16'(PwmTop);

  ppmd_state_e state_q, state_d;

  logic signed [31:0] kp_q, ki_q, kd_q;
  logic        [15:0] dt_q;
  logic signed [31:0] last_q, err_q, deriv_q;
  logic signed [47:0] sum_q;
  bridge_mode_e       mode_q;
  logic               neg_q, fwd_q, chg_q;
  logic        [3:0]  step_q, tag_q;
  logic               acc_en_q;
  logic signed [49:0] prod_q;
  logic signed [66:0] pd_q;
  logic signed [81:0] i_q;
  logic [DIV_DEN_W-1:0] mag_q;
  logic        [38:0] scl_q;
  logic        [13:0] duty_q;
  logic               out_valid_q;
  out_item_t          out_data_q;

  logic               in_acc, div_start, load_out;
  logic [DIV_NUM_W-1:0] div_num, quo;
  logic [DIV_DEN_W-1:0] div_den;
  div_stat_t          div_stat;
  logic        [15:0] dt_eff;
  logic signed [32:0] pos_diff, err_diff;
  logic signed [31:0] err_now, deriv_now;
  logic        [32:0] diff_mag;
  logic signed [32:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [49:0] mul_p;
  logic signed [50:0] sum_add;
  logic signed [47:0] sum_new;
  logic signed [63:0] pd_sat, i_term, u_val;
  logic signed [64:0] u_sum;
  logic        [63:0] u_abs;
  logic [DIV_DEN_W-1:0] mag_now;
  logic               fwd_now;
  bridge_mode_e       dir_now;
  logic        [47:0] rcp_sum;

  assign cfg_ready_o = 1'b1;
  assign dt_eff      = (dt_q == 16'd0) ? 16'd1 : dt_q;

  // Write configuration registers; drop unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q <= '0;
      ki_q <= '0;
      kd_q <= '0;
      dt_q <= 16'hFFFF;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_GAIN_P: kp_q <= cfg_data_i;
        REG_GAIN_I: ki_q <= cfg_data_i;
        REG_GAIN_D: kd_q <= cfg_data_i;
        REG_PERIOD: dt_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Saturated error and derivative numerator at acceptance
  always_comb begin
    pos_diff = 33'(in_data_i.encoder_position) - 33'(in_data_i.target_position);
    if (pos_diff[32] != pos_diff[31]) begin
      err_now = pos_diff[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end else begin
      err_now = pos_diff[31:0];
    end
    err_diff = 33'(err_now) - 33'(last_q);
    diff_mag = err_diff[32] ? 33'(-err_diff) : err_diff;
  end

  // Signed, saturated derivative from the divider magnitude
  always_comb begin
    if (!neg_q) begin
      deriv_now = (quo > 49'h7FFFFFFF) ? 32'sh7FFFFFFF : quo[31:0];
    end else begin
      deriv_now = (quo > 49'h80000000) ? 32'sh80000000 : (~quo[31:0] + 32'd1);
    end
  end

  // Select shared multiplier operands
  always_comb begin
    mul_a = 33'(kp_q);
    mul_b = '0;
    if (state_q == ST_SCALE) begin
      mul_a = {10'd0, mag_q};
      mul_b = {1'b0, PwmTopW};
    end else if (state_q == ST_RCP_LO) begin
      mul_a = {10'd0, prod_q[38:16]};
      mul_b = {1'b0, DUTY_RECIP[15:0]};
    end else if (state_q == ST_RCP_HI) begin
      mul_a = {10'd0, mag_q};
      mul_b = {9'd0, DUTY_RECIP[23:16]};
    end else begin
      case (step_q)
        STEP_SUM:  begin mul_a = 33'(err_q); mul_b = {1'b0, dt_eff}; end
        STEP_P_LO: begin mul_a = 33'(kp_q); mul_b = {1'b0, err_q[15:0]}; end
        STEP_P_HI: begin mul_a = 33'(kp_q); mul_b = {err_q[31], err_q[31:16]}; end
        STEP_D_LO: begin mul_a = 33'(kd_q); mul_b = {1'b0, deriv_q[15:0]}; end
        STEP_D_HI: begin mul_a = 33'(kd_q); mul_b = {deriv_q[31], deriv_q[31:16]}; end
        STEP_I_0:  begin mul_a = 33'(ki_q); mul_b = {1'b0, sum_q[15:0]}; end
        STEP_I_1:  begin mul_a = 33'(ki_q); mul_b = {1'b0, sum_q[31:16]}; end
        STEP_I_2:  begin mul_a = 33'(ki_q); mul_b = {sum_q[47], sum_q[47:32]}; end
        default:   begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  assign mul_p = 50'(mul_a * mul_b);

  // Join the two reciprocal halves; bits above DUTY_SHIFT are the duty
  assign rcp_sum = 48'(scl_q) + {1'b0, prod_q[30:0], 16'd0};

  // Saturated error sum update
  always_comb begin
    sum_add = 51'(sum_q) + 51'(prod_q);
    if (sum_add > 51'sh7FFFFFFFFFFF) begin
      sum_new = 48'sh7FFFFFFFFFFF;
    end else if (sum_add < -51'sh800000000000) begin
      sum_new = 48'sh800000000000;
    end else begin
      sum_new = sum_add[47:0];
    end
  end

  // Combine terms into u, then magnitude and direction
  always_comb begin
    if (pd_q[66:63] != {4{pd_q[66]}}) begin
      pd_sat = pd_q[66] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      pd_sat = pd_q[63:0];
    end
    i_term = i_q[79:16];
    u_sum  = 65'(pd_sat) + 65'(i_term);
    if (u_sum[64] != u_sum[63]) begin
      u_val = u_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      u_val = u_sum[63:0];
    end
    u_abs   = u_val[63] ? 64'(-u_val) : 64'(u_val);
    mag_now = (u_abs > 64'(FULL_POWER_Q16)) ? FULL_POWER_Q16 : u_abs[DIV_DEN_W-1:0];
    fwd_now = !u_val[63] && (u_val != 64'sd0);
    dir_now = fwd_now ? MODE_FORWARD : MODE_REVERSE;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (in_valid_i) state_d = ST_DIV_D;
      ST_DIV_D:   if (div_stat.done) state_d = ST_MUL;
      ST_MUL:     if (step_q == STEP_DRAIN) state_d = ST_FIN;
      ST_FIN:     state_d = ST_SCALE;
      ST_SCALE:   state_d = ST_RCP_LO;
      ST_RCP_LO:  state_d = ST_RCP_HI;
      ST_RCP_HI:  state_d = ST_RCP_SUM;
      ST_RCP_SUM: state_d = ST_HOLD;
      ST_HOLD:    if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    in_acc     = 1'b0;
    div_start  = 1'b0;
    div_num    = {diff_mag, 16'd0};
    div_den    = {7'd0, dt_eff};
    load_out   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        in_acc     = in_valid_i;
        div_start  = in_valid_i;
      end
      ST_HOLD: load_out = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  ppmd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .stat_o     (div_stat),
    .quotient_o (quo)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STEP_SUM;
      acc_en_q    <= 1'b0;
      last_q      <= '0;
      sum_q       <= '0;
      mode_q      <= MODE_BRAKE;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      acc_en_q <= (state_q == ST_MUL) && (step_q != STEP_DRAIN);
      if (state_q == ST_MUL) begin
        step_q <= step_q + 4'd1;
      end else begin
        step_q <= STEP_SUM;
      end
      if (acc_en_q && (tag_q == STEP_SUM)) begin
        sum_q <= sum_new;
      end
      if (state_q == ST_FIN) begin
        last_q <= err_q;
        mode_q <= dir_now;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers and accumulators
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    tag_q  <= step_q;
    if (in_acc) begin
      err_q <= err_now;
      neg_q <= err_diff[32];
      pd_q  <= '0;
      i_q   <= '0;
    end
    if ((state_q == ST_DIV_D) && div_stat.done) begin
      deriv_q <= deriv_now;
    end
    if (acc_en_q) begin
      case (tag_q)
        STEP_P_LO, STEP_D_LO: pd_q <= pd_q + 67'(prod_q);
        STEP_P_HI, STEP_D_HI: pd_q <= pd_q + (67'(prod_q) <<< 16);
        STEP_I_0:             i_q  <= i_q + 82'(prod_q);
        STEP_I_1:             i_q  <= i_q + (82'(prod_q) <<< 16);
        STEP_I_2:             i_q  <= i_q + (82'(prod_q) <<< 32);
        default: ;
      endcase
    end
    if (state_q == ST_FIN) begin
      mag_q <= mag_now;
      fwd_q <= fwd_now;
      chg_q <= (dir_now != mode_q);
    end
    // Keep the scaled magnitude over 65536 for the high reciprocal half
    if (state_q == ST_RCP_LO) begin
      mag_q <= prod_q[38:16];
    end
    if (state_q == ST_RCP_HI) begin
      scl_q <= prod_q[38:0];
    end
    if (state_q == ST_RCP_SUM) begin
      duty_q <= rcp_sum[DUTY_SHIFT+13:DUTY_SHIFT];
    end
    if (load_out) begin
      out_data_q.duty_level        <= duty_q;
      out_data_q.drive_forward     <= fwd_q;
      out_data_q.drive_reverse     <= !fwd_q;
      out_data_q.direction_changed <= chg_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Checks on the core's own logic
  `PPMD_ASSERT_IMP(a_dir_exclusive, out_valid_o,
                   out_data_o.drive_forward ^ out_data_o.drive_reverse)
  `PPMD_ASSERT_IMP(a_duty_range, out_valid_o,
                   (PwmTop > 16383) || (out_data_o.duty_level <= 14'(PwmTop)))
  `PPMD_ASSERT_IMP(a_div_done_state, div_stat.done, state_q == ST_DIV_D)

endmodule
`default_nettype wire

// File: design/ppmd_div.sv
// Serial restoring divider, one quotient bit per cycle.
// Depends on ppmd_pkg for widths and the status struct.
`timescale 1ns / 1ps
`default_nettype none
module ppmd_div import ppmd_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [DIV_NUM_W-1:0] dividend_i,
  input  wire logic [DIV_DEN_W-1:0] divisor_i,
  output div_stat_t                 stat_o,
  output logic      [DIV_NUM_W-1:0] quotient_o
);

  localparam logic [DIV_CNT_W-1:0] CntLast = DIV_CNT_W'(DIV_NUM_W - 1);

  logic [DIV_NUM_W-1:0] quo_q;
  logic [DIV_DEN_W-1:0] rem_q, den_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;
  logic [DIV_DEN_W:0]   rem_sh, rem_sub;
  logic                 ge;

  // Shift in the next dividend bit and try the subtract
  always_comb begin
    rem_sh  = {rem_q, quo_q[DIV_NUM_W-1]};
    ge      = rem_sh >= {1'b0, den_q};
    rem_sub = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
  end

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
      rem_q <= rem_sub[DIV_DEN_W-1:0];
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule
`default_nettype wire

// File: sim/tb_pid_position_motor_drive_core.sv
// Testbench for the PID position motor drive core: directed and random beats
// checked against a bit-accurate predictor of the control law.
// Depends on ppmd_pkg and pid_position_motor_drive_core.
`timescale 1ns / 1ps
module tb_pid_position_motor_drive_core;
  import ppmd_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  localparam longint PwmTopL = 12500;
  localparam longint FullQ16 = 100 * 65536;
  localparam longint Lim48Hi = (64'sd1 <<< 47) - 1;
  localparam longint Lim48Lo = -(64'sd1 <<< 47);

  pid_position_motor_drive_core uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #6 clk_i = ~clk_i;

  // Controller state mirrored by the predictor
  longint       kp, ki, kd, period;
  longint       prev_err, err_acc;
  bridge_mode_e mode;
  out_item_t    drive_q[$];
  int           mismatches = 0;
  bit           random_out_stall = 1'b1;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic longint sat(input longint x, input longint lo, input longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic longint sat_sum(input longint a, input longint b);
    longint s;
    s = a + b;
    if (a > 0 && b > 0 && s < 0) return 64'h7fffffffffffffff;
    if (a < 0 && b < 0 && s >= 0) return 64'sh8000000000000000;
    return s;
  endfunction

  // Work out the drive beat for one position pair and advance the state
  function automatic out_item_t predict_drive(input in_item_t b);
    longint dt, e, dv, lo, hi, prod, ti, u, mag, duty;
    bridge_mode_e dir;
    out_item_t r;
    dt = (period == 0) ? 1 : period;
    e = sat(longint'(b.encoder_position) - longint'(b.target_position),
            -64'sd2147483648, 64'sd2147483647);
    dv = sat(((e - prev_err) * 65536) / dt, -64'sd2147483648, 64'sd2147483647);
    err_acc = sat(err_acc + e * dt, Lim48Lo, Lim48Hi);
    lo = err_acc & 64'hffff;
    hi = (err_acc - lo) / 65536;
    prod = ki * lo;
    ti = ki * hi + (prod >>> 16);
    u = sat_sum(sat_sum(kp * e, kd * dv), ti);
    mag = (u < 0) ? -u : u;
    if (u == 64'sh8000000000000000 || mag > FullQ16) mag = FullQ16;
    duty = (mag * PwmTopL) / FullQ16;
    dir = (u > 0) ? MODE_FORWARD : MODE_REVERSE;
    r.direction_changed = (dir != mode);
    mode = dir;
    prev_err = e;
    r.duty_level = duty[13:0];
    r.drive_forward = (mode == MODE_FORWARD);
    r.drive_reverse = (mode == MODE_REVERSE);
    return r;
  endfunction

  // Write one register; drop valid again before the next write
  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_GAIN_P: kp = longint'(signed'(val));
      REG_GAIN_I: ki = longint'(signed'(val));
      REG_GAIN_D: kd = longint'(signed'(val));
      REG_PERIOD: period = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_gains(input logic [31:0] p, input logic [31:0] i,
                           input logic [31:0] d, input logic [15:0] dt);
    write_reg(REG_GAIN_P, p);
    write_reg(REG_GAIN_I, i);
    write_reg(REG_GAIN_D, d);
    write_reg(REG_PERIOD, {16'd0, dt});
  endtask

  // Send one position beat after a random gap; hold it until accepted
  task automatic send_position(input logic [31:0] enc, input logic [31:0] tgt);
    in_item_t b;
    int gap;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) gap = 0;
    // valid drops between beats
    @(posedge clk_i);
    repeat (gap) @(posedge clk_i);
    b.encoder_position = enc;
    b.target_position = tgt;
    in_valid_i <= 1'b1;
    in_data_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    in_valid_i <= 1'b0;
    drive_q.push_back(predict_drive(b));
  endtask

  task automatic drain();
    wait (drive_q.size() == 0);
    repeat (150) @(posedge clk_i);
  endtask

  // Receiver: random stall per beat while random_out_stall is set, compare each accepted beat
  initial begin
    out_item_t want;
    int hold;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (drive_q.size() == 0) begin
          report("unexpected beat", out_data_o, 0);
        end else begin
          want = drive_q.pop_front();
          if (out_data_o.duty_level !== want.duty_level)
            report("duty_level", out_data_o.duty_level, want.duty_level);
          if (out_data_o.drive_forward !== want.drive_forward)
            report("drive_forward", out_data_o.drive_forward, want.drive_forward);
          if (out_data_o.drive_reverse !== want.drive_reverse)
            report("drive_reverse", out_data_o.drive_reverse, want.drive_reverse);
          if (out_data_o.direction_changed !== want.direction_changed)
            report("direction_changed", out_data_o.direction_changed,
                   want.direction_changed);
        end
        hold = random_out_stall ? $urandom_range(0, 4) : 0;
        out_stall_i <= (hold != 0);
      end else if (out_stall_i) begin
        out_stall_i <= ($urandom_range(0, 4) != 0);
      end
    end
  end

  task automatic test_defaults();
    send_position(32'd0, 32'd0);
    send_position(32'd100, 32'd0);
    drain();
  endtask

  task automatic test_extremes();
    set_gains(32'h0001_0000, 32'h0000_0100, 32'h0000_0010, 16'd65535);
    send_position(32'h7fff_ffff, 32'h8000_0000);
    send_position(32'h8000_0000, 32'h7fff_ffff);
    send_position(32'h8000_0000, 32'h7fff_ffff);
    send_position(32'hffff_ffff, 32'h0000_0000);
    send_position(32'd50, 32'd0);
    send_position(32'd50, 32'd0);
    drain();
    set_gains(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 16'd1);
    send_position(32'h7fff_ffff, 32'h8000_0000);
    send_position(32'h8000_0000, 32'h7fff_ffff);
    send_position(32'd3, 32'd1);
    drain();
    // zero period counts as one; full-scale gains give a large u
    set_gains(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 16'd0);
    send_position(32'd1, 32'd0);
    send_position(32'd0, 32'd1);
    drain();
    set_gains(32'h0000_0001, 32'd0, 32'd0, 16'd1000);
    send_position(32'd1, 32'd0);
    send_position(32'd99, 32'd0);
    send_position(32'd0, 32'd0);
    drain();
    // index outside the map must be dropped
    cfg_valid_i <= 1'b1;
    cfg_index_i <= 8'd77;
    cfg_data_i <= 32'hdead_beef;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    send_position(32'd5, 32'd3);
    drain();
  endtask

  task automatic test_random();
    logic [31:0] enc, tgt;
    for (int ph = 0; ph < 8; ph++) begin
      set_gains($urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0008_0000),
                $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0000_1000),
                $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0000_1000),
                $urandom_range(0, 65535));
      random_out_stall = (ph != 3);
      tgt = $urandom;
      for (int n = 0; n < 200; n++) begin
        if ($urandom_range(0, 3) == 0) tgt = $urandom;
        case ($urandom_range(0, 3))
          0: enc = $urandom;
          default: enc = tgt + $urandom_range(0, 400) - 200;
        endcase
        send_position(enc, tgt);
        if (n == 100 && ph == 1) wait (drive_q.size() == 0);
      end
      drain();
    end
  endtask

  initial begin
    kp = 0; ki = 0; kd = 0; period = 65535;
    prev_err = 0; err_acc = 0; mode = MODE_BRAKE;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_defaults();
    test_extremes();
    test_random();
    if (mismatches == 0) begin
      $display("pid_position_motor_drive_core regression: pass");
    end else begin
      $display("pid_position_motor_drive_core regression: fail");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("pid_position_motor_drive_core regression: fail");
    $finish;
  end
endmodule

// File: filelist.f
+incdir+design
design/ppmd_pkg.sv
design/ppmd_div.sv
design/pid_position_motor_drive_core.sv
sim/tb_pid_position_motor_drive_core.sv
